### design/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg - shared types and constants of the integer-to-ASCII formatter
// Cell opcodes, field widths and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
`default_nettype none
package ita_pkg;

	localparam int MAG_W       = 64;
	localparam int WIDTH_W     = 7;
	localparam int MAX_WIDTH   = 64;
	localparam int DIGIT_CELLS = 20;
	localparam int HEX_DIGITS  = 16;
	localparam int ND_W        = $clog2(DIGIT_CELLS + 1);
	localparam int CNT_W       = $clog2(MAG_W);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_LOAD   = 2'd1,
		CELL_DABBLE = 2'd2,
		CELL_SHIFT  = 2'd3
	} cell_op_t;

	// Map one digit value to its ASCII code.
	function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic upper);
		logic [7:0] r;
		if (d < 4'd10) begin
			r = CH_ZERO + {4'd0, d};
		end else if (upper) begin
			r = 8'h41 + {4'd0, d - 4'd10};
		end else begin
			r = 8'h61 + {4'd0, d - 4'd10};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### design/integer_to_ascii_padded_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_padded_core - padded decimal / hex integer formatter
// Turns a 64-bit magnitude into a stream of ASCII characters with an
// optional minus sign and space or zero padding to a minimum width.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                                    | tuser / tlast
//  --------+-----+------------------------------------------+------------------------
//  s_*     | in  | magnitude, negative, min_width, zero_fill | base_is_hex, uppercase
//  m_*     | out | character                                | tlast = last
//
// One number is taken at a time. Decimal runs bit-serial double
// dabble through a row of 20 BCD cells, hex loads the cells directly; then
// leading zero digits are stripped to settle on the top one, the pad count
// is worked out, and one character goes out per cycle while m_tready does
// not stall (up to 64 characters).
// Reset clears the sequencer and the output valid; the cells need none.
// A stalled m_tready holds the current character and freezes the emit sequence.
// s_tready rises again once the last character sits in the output register.
`default_nettype none
module integer_to_ascii_padded_core
	import ita_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [63:0] magnitude, [64] negative, [71:65] min_width, [72] zero_fill
	input  wire logic [79:0] s_tdata,
	// [0] base_is_hex, [1] uppercase
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] character
	output logic [7:0]       m_tdata,
	output logic             m_tlast
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_NORM = 3'd2;
	localparam logic [2:0] ST_PAD  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]         state_q;
	logic [MAG_W-1:0]   mag_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ND_W-1:0]    nd_q;
	logic [WIDTH_W-1:0] width_q;
	logic [WIDTH_W-1:0] pad_q;
	logic               neg_q;
	logic               zpad_q;
	logic               upper_q;
	logic               m_valid_q;
	logic [7:0]         m_char_q;
	logic               m_last_q;

	logic               take;
	logic               adv;
	cell_op_t           op;
	logic [3:0]         digit [DIGIT_CELLS];
	logic               carry [DIGIT_CELLS];
	logic [3:0]         top_digit;
	logic [WIDTH_W-1:0] used;
	logic [WIDTH_W-1:0] width_in;
	logic               emit_digit;

	assign s_tready  = (state_q == ST_IDLE);
	assign take      = s_tvalid && s_tready;
	assign adv       = !m_valid_q || m_tready;
	assign top_digit = digit[DIGIT_CELLS-1];
	assign used      = WIDTH_W'(nd_q) + WIDTH_W'(neg_q);
	assign width_in  = (s_tdata[71:65] > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH)
	                                                          : s_tdata[71:65];
	// digits go out once padding and sign are done
	assign emit_digit = !((pad_q != '0) || neg_q);

	// Pick what the cell row does this cycle.
	always_comb begin
		op = CELL_HOLD;
		unique case (state_q)
			ST_IDLE: if (take) op = CELL_LOAD;
			ST_CONV: op = CELL_DABBLE;
			ST_NORM: if (top_digit == 4'd0 && nd_q != ND_W'(1)) op = CELL_SHIFT;
			ST_EMIT: if (adv && emit_digit) op = CELL_SHIFT;
			default: op = CELL_HOLD;
		endcase
	end

	// Cell row: cell 0 is the least significant digit, the top cell the most.
	// Hex loads nibbles aligned to the top; decimal clears and dabbles.
	for (genvar i = 0; i < DIGIT_CELLS; i++) begin : g_cell
		logic [3:0] ld;
		logic       bin;
		logic [3:0] din;
		if (i >= DIGIT_CELLS - HEX_DIGITS) begin : g_hex
			assign ld = s_tuser[0] ? s_tdata[(i-(DIGIT_CELLS-HEX_DIGITS))*4 +: 4] : 4'd0;
		end else begin : g_dec
			assign ld = 4'd0;
		end
		if (i == 0) begin : g_first
			assign bin = mag_q[MAG_W-1];
			assign din = 4'd0;
		end else begin : g_next
			assign bin = carry[i-1];
			assign din = digit[i-1];
		end
		ita_cell u_cell (
			.clk       (clk),
			.op        (op),
			.load_digit(ld),
			.bit_in    (bin),
			.digit_in  (din),
			.carry_out (carry[i]),
			.digit     (digit[i])
		);
	end

	// Sequencer: convert, strip leading zeros, size the pad, emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			// raise valid with each new character, drop it once the sink takes it
			if (state_q == ST_EMIT && adv) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) state_q <= s_tuser[0] ? ST_NORM : ST_CONV;
				end
				ST_CONV: begin
					if (cnt_q == CNT_W'(MAG_W - 1)) state_q <= ST_NORM;
				end
				ST_NORM: begin
					if (top_digit != 4'd0 || nd_q == ND_W'(1)) state_q <= ST_PAD;
				end
				ST_PAD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (adv && emit_digit && nd_q == ND_W'(1)) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers: no reset, qualified by the sequencer state.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					mag_q   <= s_tdata[63:0];
					neg_q   <= s_tdata[64];
					width_q <= width_in;
					zpad_q  <= s_tdata[72];
					upper_q <= s_tuser[1];
					cnt_q   <= '0;
					nd_q    <= s_tuser[0] ? ND_W'(HEX_DIGITS) : ND_W'(DIGIT_CELLS);
				end
			end
			ST_CONV: begin
				mag_q <= {mag_q[MAG_W-2:0], 1'b0};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_NORM: begin
				if (top_digit == 4'd0 && nd_q != ND_W'(1)) nd_q <= nd_q - ND_W'(1);
			end
			ST_PAD: begin
				pad_q <= (width_q > used) ? width_q - used : '0;
			end
			ST_EMIT: begin
				if (adv) begin
					priority if (!zpad_q && pad_q != '0) begin
						m_char_q <= CH_SPACE;
						m_last_q <= 1'b0;
						pad_q    <= pad_q - WIDTH_W'(1);
					end else if (neg_q) begin
						m_char_q <= CH_MINUS;
						m_last_q <= 1'b0;
						neg_q    <= 1'b0;
					end else if (pad_q != '0) begin
						m_char_q <= CH_ZERO;
						m_last_q <= 1'b0;
						pad_q    <= pad_q - WIDTH_W'(1);
					end else begin
						m_char_q <= digit_ascii(top_digit, upper_q);
						m_last_q <= (nd_q == ND_W'(1));
						nd_q     <= nd_q - ND_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_char_q;
	assign m_tlast  = m_last_q;

endmodule
`default_nettype wire

### design/ita_cell.sv
// ----------------------------------------------------------------------------
// ita_cell - one digit cell of the conversion row
// Holds one digit; dabbles a bit in from below or takes the lower digit.
// ----------------------------------------------------------------------------
`default_nettype none
module ita_cell
	import ita_pkg::*;
(
	input  wire logic     clk,
	input  wire cell_op_t op,
	input  wire logic [3:0] load_digit,
	input  wire logic     bit_in,
	input  wire logic [3:0] digit_in,
	output logic          carry_out,
	output logic [3:0]    digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// add 3 to a digit of five or more before the shift
	assign adj       = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign carry_out = adj[3];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_LOAD:   digit_q <= load_digit;
			CELL_DABBLE: digit_q <= {adj[2:0], bit_in};
			CELL_SHIFT:  digit_q <= digit_in;
			default:     digit_q <= digit_q;
		endcase
	end

endmodule
`default_nettype wire

### design/ita_checker.sv
// ----------------------------------------------------------------------------
// ita_checker - port-level checks of the integer-to-ASCII formatter
// Watches the stream ports only; bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module ita_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [79:0] s_tdata,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic        m_tlast
);

	// a stalled character holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed under stall");

	// one number at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// no new number while a non-final character is pending
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("ready in the middle of a number");

	// only pad, sign, digits or hex letters leave the block
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == 8'h20) || (m_tdata == 8'h2D) ||
		(m_tdata >= 8'h30 && m_tdata <= 8'h39) ||
		(m_tdata >= 8'h41 && m_tdata <= 8'h46) ||
		(m_tdata >= 8'h61 && m_tdata <= 8'h66))
		else $error("illegal character");

endmodule

bind integer_to_ascii_padded_core ita_checker u_ita_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
`default_nettype wire
